FILE: sv/sltd_pkg.sv
// shared types and constants for the sync / length / tail deframer
package sltd_pkg;

  localparam int SLTD_SYNC_BYTES = 4;
  localparam int SLTD_QUEUE_DEPTH = 4;

  localparam int SYNC_REG_W = 32;
  localparam int TAIL_REG_W = 16;

  // register indexes of the configuration port
  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  // event kinds
  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  frame_code;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } queue_head_t;

endpackage

FILE: sv/sltd_front.sv
// front part: sync hunt, header parse, payload and tail classification
module sltd_front import sltd_pkg::*; #(
  parameter int SYNC_BYTES = SLTD_SYNC_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SYNC_REG_W-1:0] cfg_data,
  input  logic                  take,
  input  logic [7:0]            rx_byte,
  output logic                  ev_push,
  output event_t                ev_out
);

  localparam int WIN_W  = 8 * SYNC_BYTES;
  localparam int FILL_W = $clog2(SYNC_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SYNC_BYTES);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_CODE    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_TAIL1   = 3'd5;
  localparam logic [2:0] PH_TAIL2   = 3'd6;

  logic [SYNC_REG_W-1:0] sync_pattern;
  logic [TAIL_REG_W-1:0] tail_pattern;
  logic [2:0]            phase;
  logic [WIN_W-1:0]      sync_window;
  logic [FILL_W-1:0]     sync_fill;
  logic [15:0]           payload_length;
  logic [15:0]           payload_count;
  logic [7:0]            code_held;
  logic                  tail_first_ok;

  logic [63:0]       pattern_wide;
  logic [WIN_W-1:0]  pattern_win;
  logic [WIN_W-1:0]  window_next;
  logic [FILL_W-1:0] fill_next;
  logic [15:0]       count_next;
  logic              tail_ok;

  assign pattern_wide = {32'd0, sync_pattern};
  assign pattern_win  = pattern_wide[WIN_W-1:0];
  assign window_next  = WIN_W'({sync_window, rx_byte});
  assign fill_next    = (sync_fill < FILL_FULL) ? sync_fill + 1'b1 : sync_fill;
  assign count_next   = payload_count + 16'd1;
  assign tail_ok      = tail_first_ok && (rx_byte == tail_pattern[7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
      tail_pattern <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC: sync_pattern <= cfg_data;
        REG_TAIL: tail_pattern <= cfg_data[TAIL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      sync_window    <= '0;
      sync_fill      <= '0;
      payload_length <= '0;
      payload_count  <= '0;
      code_held      <= '0;
      tail_first_ok  <= 1'b0;
    end else if (take) begin
      case (phase)
        PH_HUNT: begin
          sync_window <= window_next;
          sync_fill   <= fill_next;
          if (fill_next == FILL_FULL && window_next == pattern_win) begin
            phase <= PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          payload_length <= {rx_byte, 8'd0};
          phase          <= PH_LEN_LO;
        end
        PH_LEN_LO: begin
          payload_length <= {payload_length[15:8], rx_byte};
          phase          <= PH_CODE;
        end
        PH_CODE: begin
          code_held     <= rx_byte;
          payload_count <= '0;
          phase         <= (payload_length == 16'd0) ? PH_TAIL1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          payload_count <= count_next;
          if (count_next >= payload_length) begin
            phase <= PH_TAIL1;
          end
        end
        PH_TAIL1: begin
          tail_first_ok <= (rx_byte == tail_pattern[15:8]);
          phase         <= PH_TAIL2;
        end
        default: begin
          // tail2 and unused codes go back to hunting with an empty window
          phase       <= PH_HUNT;
          sync_window <= '0;
          sync_fill   <= '0;
        end
      endcase
    end
  end

  always_comb begin
    ev_push             = 1'b0;
    ev_out.event_kind   = EV_PAYLOAD;
    ev_out.frame_code   = code_held;
    ev_out.data_byte    = 8'd0;
    ev_out.byte_index   = 16'd0;
    ev_out.frame_length = payload_length;
    if (phase == PH_PAYLOAD) begin
      ev_push           = take;
      ev_out.data_byte  = rx_byte;
      ev_out.byte_index = payload_count;
    end else if (phase == PH_TAIL2) begin
      ev_push           = take;
      ev_out.event_kind = tail_ok ? EV_ACCEPT : EV_REJECT;
    end
  end

endmodule

FILE: sv/sltd_queue.sv
// short event queue between front and back parts
module sltd_queue import sltd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  event_t      push_ev,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);

  localparam int PTR_W = $clog2(SLTD_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(SLTD_QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLTD_QUEUE_DEPTH);

  event_t           mem [SLTD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head.valid = (count != '0);
  assign head.ev    = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/sltd_back.sv
// back part: output register that hands events to the downstream side
module sltd_back import sltd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        ev_valid,
  input  logic        ev_stall,
  output event_t      ev_reg
);

  assign pop = head.valid && (!ev_valid || !ev_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!ev_valid || !ev_stall) begin
      ev_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_reg <= head.ev;
    end
  end

endmodule

FILE: sv/sync_length_tail_deframer.sv
// top level of the sync / length / code / tail byte deframer
//
//  channel | direction | handshake           | beat carries
//  --------+-----------+---------------------+-----------------------------------------
//  rx      | in        | rx_valid / rx_stall | rx_byte
//  ev      | out       | ev_valid / ev_stall | event_kind, frame_code, data_byte,
//          |           |                     | byte_index, frame_length
//  cfg     | in        | cfg_we              | cfg_index, cfg_data (sync, tail pattern)
//
// one rx beat per cycle while rx_stall is low; the parser state advances in the
// cycle the beat is taken; any event it makes is queued at that edge
// and reaches the ev port when the output register loads it from the queue head
// rx_stall rises only when the four-entry event queue is full
// rst is synchronous: hunting, empty window, patterns zero, queue and output empty
module sync_length_tail_deframer import sltd_pkg::*; #(
  parameter int SYNC_BYTES = SLTD_SYNC_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SYNC_REG_W-1:0] cfg_data,
  // received bytes
  input  logic                  rx_valid,
  output logic                  rx_stall,
  input  logic [7:0]            rx_byte,
  // frame events
  output logic                  ev_valid,
  input  logic                  ev_stall,
  output logic [1:0]            event_kind,
  output logic [7:0]            frame_code,
  output logic [7:0]            data_byte,
  output logic [15:0]           byte_index,
  output logic [15:0]           frame_length
);

  logic        take;
  logic        q_full;
  logic        ev_push;
  event_t      front_ev;
  queue_head_t q_head;
  logic        q_pop;
  event_t      out_ev;

  // a beat is taken whenever the queue has room, even while ev is stalled
  assign rx_stall = q_full;
  assign take     = rx_valid && !rx_stall;

  sltd_front #(
    .SYNC_BYTES(SYNC_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .take     (take),
    .rx_byte  (rx_byte),
    .ev_push  (ev_push),
    .ev_out   (front_ev)
  );

  // decouples the parser from downstream back-pressure
  sltd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (ev_push),
    .push_ev(front_ev),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head)
  );

  sltd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .pop     (q_pop),
    .ev_valid(ev_valid),
    .ev_stall(ev_stall),
    .ev_reg  (out_ev)
  );

  assign event_kind   = out_ev.event_kind;
  assign frame_code   = out_ev.frame_code;
  assign data_byte    = out_ev.data_byte;
  assign byte_index   = out_ev.byte_index;
  assign frame_length = out_ev.frame_length;

endmodule

FILE: dv/tb_sync_length_tail_deframer.sv
// testbench for the sync / length / code / tail byte deframer
`timescale 1ns / 1ps

module tb_sync_length_tail_deframer;
  import sltd_pkg::*;

  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int QUIET_CYCLES      = 12;
  localparam int N_SETTINGS        = 8;
  localparam int BEATS_PER_SETTING = 90;
  localparam int MAX_REPORTS       = 30;

  // parser position inside a frame
  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_CODE, PH_PAYLOAD, PH_TAIL1, PH_TAIL2
  } parse_phase_t;

  // how the tail of a generated frame is damaged
  typedef enum int {
    TAIL_GOOD, TAIL_BAD_FIRST, TAIL_BAD_SECOND, TAIL_BAD_BOTH
  } tail_fault_t;

  // tracks parser state and the events the block owes us
  class frame_event_checker;
    logic [31:0]  sync_pat;
    logic [15:0]  tail_pat;
    parse_phase_t phase;
    logic [63:0]  window;
    int           fill;
    logic [15:0]  plen;
    logic [15:0]  pcount;
    logic [7:0]   code;
    bit           tail1_ok;
    event_t       due_events[$];
    int           errors;
    int           n_payload;
    int           n_accept;
    int           n_reject;

    function new();
      sync_pat  = '0;
      tail_pat  = '0;
      phase     = PH_HUNT;
      window    = '0;
      fill      = 0;
      plen      = '0;
      pcount    = '0;
      code      = '0;
      tail1_ok  = 1'b0;
      errors    = 0;
      n_payload = 0;
      n_accept  = 0;
      n_reject  = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] d);
      if (idx == REG_SYNC) sync_pat = d;
      else tail_pat = d[15:0];
    endfunction

    function void owe(logic [1:0] kind, logic [7:0] data, logic [15:0] idx);
      event_t e;
      e.event_kind   = kind;
      e.frame_code   = code;
      e.data_byte    = data;
      e.byte_index   = idx;
      e.frame_length = plen;
      due_events.insert(due_events.size(), e);
    endfunction

    // advance the parser by one accepted rx beat
    function void note_byte(logic [7:0] b);
      logic [63:0] mask;
      mask = ~64'd0 >> (64 - 8 * SLTD_SYNC_BYTES);
      case (phase)
        PH_HUNT: begin
          window = ((window << 8) | {56'd0, b}) & mask;
          if (fill < SLTD_SYNC_BYTES) fill++;
          // a match needs a full window gathered since hunting began
          if (fill >= SLTD_SYNC_BYTES && window == ({32'd0, sync_pat} & mask))
            phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          plen  = {b, 8'h00};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          plen  = plen + {8'h00, b};
          phase = PH_CODE;
        end
        PH_CODE: begin
          code   = b;
          pcount = '0;
          phase  = (plen == 16'd0) ? PH_TAIL1 : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          owe(EV_PAYLOAD, b, pcount);
          pcount = pcount + 16'd1;
          if (pcount >= plen) phase = PH_TAIL1;
        end
        PH_TAIL1: begin
          tail1_ok = (b == tail_pat[15:8]);
          phase    = PH_TAIL2;
        end
        default: begin
          owe((tail1_ok && b == tail_pat[7:0]) ? EV_ACCEPT : EV_REJECT, 8'h00, 16'h0000);
          phase  = PH_HUNT;
          window = '0;
          fill   = 0;
        end
      endcase
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    // one accepted ev beat against the oldest owed event
    function void check_event(event_t got);
      event_t want;
      if (due_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: event with none owed, expected nothing, got kind %0d code 0x%0h",
                   $time, got.event_kind, got.frame_code);
        return;
      end
      want = due_events.pop_front();
      compare("event_kind", 16'(want.event_kind), 16'(got.event_kind));
      compare("frame_code", 16'(want.frame_code), 16'(got.frame_code));
      compare("data_byte", 16'(want.data_byte), 16'(got.data_byte));
      compare("byte_index", want.byte_index, got.byte_index);
      compare("frame_length", want.frame_length, got.frame_length);
      case (want.event_kind)
        EV_PAYLOAD: n_payload++;
        EV_ACCEPT:  n_accept++;
        default:    n_reject++;
      endcase
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_SYNC;
  logic [31:0] cfg_data = '0;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        ev_valid;
  logic        ev_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [7:0]  frame_code;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] frame_length;

  frame_event_checker sb;
  bit calm = 1'b0;      // no idling on either side
  int beats_sent = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  sync_length_tail_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .ev_valid     (ev_valid),
    .ev_stall     (ev_stall),
    .event_kind   (event_kind),
    .frame_code   (frame_code),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .frame_length (frame_length)
  );

  // ev side: check every accepted beat
  always @(posedge clk) begin
    if (!rst && ev_valid && !ev_stall)
      sb.check_event({event_kind, frame_code, data_byte, byte_index, frame_length});
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((rx_valid && !rx_stall) || (ev_valid && !ev_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d events still owed",
               $time, WATCHDOG_LIMIT, sb.due_events.size());
      $display("tb_sync_length_tail_deframer NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ev side back-pressure in bursts of random length
  initial begin
    wait (!rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        ev_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        ev_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // one rx beat, with an occasional gap before it
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    sb.note_byte(b);
    beats_sent++;
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // sender holds off until every owed event is out, then lets the block settle
  task automatic wait_quiet();
    rx_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_events.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // only called while quiet
  task automatic set_patterns(input logic [31:0] s, input logic [15:0] t);
    logic [31:0] tail_word;
    tail_word = {16'($urandom), t};   // upper bits are not part of the register
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_TAIL;
    cfg_data  <= tail_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_SYNC, s);
    sb.write_reg(REG_TAIL, tail_word);
    n_settings++;
  endtask

  // i-th sync byte in arrival order
  function automatic logic [7:0] sync_byte(int i);
    int pos;
    pos = SLTD_SYNC_BYTES - 1 - i;
    if (pos > 3) return 8'h00;
    return sb.sync_pat[8*pos +: 8];
  endfunction

  // mostly short payloads, some empty, a few long
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 16'd0;
    if (r < 18) return 16'($urandom_range(1, 12));
    return 16'($urandom_range(13, 300));
  endfunction

  task automatic send_frame(input logic [15:0] len, input tail_fault_t fault,
                            input bit embed_sync);
    logic [7:0] t_hi;
    logic [7:0] t_lo;
    t_hi = sb.tail_pat[15:8];
    t_lo = sb.tail_pat[7:0];
    if (fault == TAIL_BAD_FIRST || fault == TAIL_BAD_BOTH)
      t_hi = t_hi ^ 8'($urandom_range(1, 255));
    if (fault == TAIL_BAD_SECOND || fault == TAIL_BAD_BOTH)
      t_lo = t_lo ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < SLTD_SYNC_BYTES; i++) send_byte(sync_byte(i));
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(8'($urandom));
    // a sync pattern inside the payload must not restart the parser
    for (int i = 0; i < len; i++)
      send_byte((embed_sync && i < SLTD_SYNC_BYTES) ? sync_byte(i) : 8'($urandom));
    send_byte(t_hi);
    send_byte(t_lo);
  endtask

  // a sync prefix cut short by a byte that cannot continue it
  task automatic send_broken_sync();
    int         p;
    logic [7:0] b;
    p = $urandom_range(1, SLTD_SYNC_BYTES - 1);
    for (int i = 0; i < p; i++) send_byte(sync_byte(i));
    do b = 8'($urandom); while (b == sync_byte(p));
    send_byte(b);
  endtask

  initial begin
    logic [7:0] seq[$];
    int         stop_at;
    int         pick;

    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero pattern after reset: four bytes since hunting began, then an empty frame
    seq = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h00, 8'h00};
    send_seq(seq);
    wait_quiet();

    // all-ones patterns, two payload beats, second tail byte wrong
    set_patterns(32'hFFFF_FFFF, 16'hFFFF);
    seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'hC3, 8'h00, 8'hFF, 8'hFF, 8'hFE};
    send_seq(seq);
    wait_quiet();

    // overlapping sync start, first tail byte wrong, then a clean frame
    set_patterns(32'hA5A5_A5C3, 16'h55AA);
    seq = '{8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hC3, 8'h00, 8'h01, 8'h80, 8'hA5,
            8'h00, 8'hAA, 8'hA5, 8'hA5, 8'hA5, 8'hC3, 8'h00, 8'h01, 8'h7F, 8'h3C,
            8'h55, 8'hAA};
    send_seq(seq);
    wait_quiet();

    // one frame past 256 bytes, so the length high byte and index bit 8 are used
    set_patterns($urandom, 16'($urandom));
    send_frame(16'h0102, TAIL_GOOD, 1'b0);
    wait_quiet();

    // random part: one pattern setting per stretch, extremes first, last stretch calm
    for (int k = 0; k < N_SETTINGS; k++) begin
      case (k)
        0:       set_patterns(32'h0000_0000, 16'h0000);
        1:       set_patterns(32'hFFFF_FFFF, 16'hFFFF);
        default: set_patterns($urandom, 16'($urandom));
      endcase
      calm    = (k == N_SETTINGS - 1);
      stop_at = beats_sent + BEATS_PER_SETTING;
      while (beats_sent < stop_at) begin
        // flush any partial frame left by noise that happened to sync
        while (sb.phase != PH_HUNT) send_byte(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_frame(pick_length(), TAIL_GOOD, 1'b0);
        else if (pick < 75)
          send_frame(pick_length(), tail_fault_t'($urandom_range(1, 3)), 1'b0);
        else if (pick < 85)
          send_broken_sync();
        else if (pick < 95)
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        else
          send_frame(pick_length() + 16'(SLTD_SYNC_BYTES), TAIL_GOOD, 1'b1);
      end
      wait_quiet();
    end

    $display("run covered %0d rx beats under %0d pattern settings", beats_sent, n_settings);
    $display("events seen: %0d payload, %0d frames accepted, %0d frames rejected",
             sb.n_payload, sb.n_accept, sb.n_reject);
    if (sb.errors == 0 && sb.due_events.size() == 0) begin
      $display("tb_sync_length_tail_deframer OK");
    end else begin
      $display("tb_sync_length_tail_deframer NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sltd_pkg.sv
sv/sltd_front.sv
sv/sltd_queue.sv
sv/sltd_back.sv
sv/sync_length_tail_deframer.sv
dv/tb_sync_length_tail_deframer.sv
